// ===== rtl/sgr_pkg.sv =====
// Shared constants and helpers for the smoothstep gradient ramp.
// No dependencies; imported by smoothstep_gradient_ramp_top.
package sgr_pkg;

    // channel and point geometry
    localparam int CH_W      = 16;              // one channel, unsigned Q0.16
    localparam int NUM_CH    = 3;               // red, green, blue
    localparam int PT_W      = CH_W * NUM_CH;   // packed control point
    localparam int H_W       = 17;              // shaped fraction, 0..65536
    localparam int BYTE_W    = 8;
    localparam int CNT_W     = 3;               // point count and segment number
    localparam int CFG_IDX_W = 3;
    localparam int PROD_W    = CH_W + H_W;      // channel times weight

    localparam logic [H_W-1:0] H_ONE = H_W'(65536);

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_POINT_COUNT  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_MODE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_POINT_0      = 3'd2;

    // channel_mode codes
    localparam logic MODE_SINGLE = 1'b0;

    // pick channel c (0 red, 1 green, 2 blue) out of a packed point
    function automatic logic [CH_W-1:0] chan_of(input logic [PT_W-1:0] p, input int c);
        return p[(NUM_CH - 1 - c) * CH_W +: CH_W];
    endfunction

    // Q0.16 channel to byte: floor((v*255 - 1) / 65536), zero stays zero
    function automatic logic [BYTE_W-1:0] to_byte(input logic [CH_W-1:0] v);
        logic [CH_W+BYTE_W-1:0] scaled;
        scaled = {v, {BYTE_W{1'b0}}} - {{BYTE_W{1'b0}}, v} - (CH_W+BYTE_W)'(1);
        if (v == '0) begin
            return '0;
        end
        return scaled[CH_W+BYTE_W-1:CH_W];
    endfunction

endpackage

// ===== rtl/smoothstep_gradient_ramp_top.sv =====
// Smoothstep gradient ramp: five-stage pipeline from ramp index to RGB bytes.
// Depends on sgr_pkg (widths, register indexes, chan_of, to_byte).
//
//  channel  | direction | handshake            | word
//  ---------+-----------+----------------------+-------------------------------------
//  request  | in        | start / busy         | i_entry_index
//  result   | out       | o_strobe (one cycle) | o_red_byte, o_green_byte, o_blue_byte
//  config   | in        | i_cfg_we             | i_cfg_index, i_cfg_data
//
// One word accepted per clock; busy is always low. Each result passes through
// the pipeline stages in order: segment multiply, segment search, smoothstep
// table read with point select, channel multiplies, blend and byte conversion.
// Synchronous active-low reset clears the valid bits and loads the register
// defaults. The receiver cannot stall, so the pipeline never holds.
module smoothstep_gradient_ramp_top
    import sgr_pkg::*;
#(
    parameter int RAMP_LENGTH = 128,
    parameter int MAX_POINTS  = 6,
    localparam int IDX_W      = $clog2(RAMP_LENGTH)
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // request
    input  logic                 start,
    output logic                 busy,
    input  logic [IDX_W-1:0]     i_entry_index,
    // result
    output logic                 o_strobe,
    output logic [BYTE_W-1:0]    o_red_byte,
    output logic [BYTE_W-1:0]    o_green_byte,
    output logic [BYTE_W-1:0]    o_blue_byte,
    // configuration
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [PT_W-1:0]      i_cfg_data
);

    localparam int D     = RAMP_LENGTH - 1;
    localparam int NUM_W = IDX_W + CNT_W;
    localparam int TAB_N = 2 ** IDX_W;

    // configuration registers
    logic [CNT_W-1:0] r_point_count;
    logic             r_channel_mode;
    logic [PT_W-1:0]  r_points [MAX_POINTS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_point_count  <= CNT_W'(2);
            r_channel_mode <= 1'b1;
            for (int k = 0; k < MAX_POINTS; k++) begin
                r_points[k] <= (k == 1) ? '1 : '0;
            end
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_POINT_COUNT:  r_point_count  <= i_cfg_data[CNT_W-1:0];
                REG_CHANNEL_MODE: r_channel_mode <= i_cfg_data[0];
                default: begin
                    for (int k = 0; k < MAX_POINTS; k++) begin
                        if (int'(i_cfg_index) == int'(REG_POINT_0) + k) begin
                            r_points[k] <= i_cfg_data;
                        end
                    end
                end
            endcase
        end
    end

    // pipeline never stalls
    assign busy = 1'b0;

    // segment count: points clamped to 1..MAX_POINTS, minus one
    logic [CNT_W-1:0] w_seg;
    always_comb begin
        if (r_point_count == '0) begin
            w_seg = '0;
        end else if (r_point_count > CNT_W'(MAX_POINTS)) begin
            w_seg = CNT_W'(MAX_POINTS - 1);
        end else begin
            w_seg = r_point_count - CNT_W'(1);
        end
    end

    // stage 1: clamp index, scale across segments
    logic             r_s1_valid;
    logic [NUM_W-1:0] r_s1_num;
    logic [CNT_W-1:0] r_s1_seg;
    logic [IDX_W-1:0] w_idx;

    assign w_idx = (i_entry_index > IDX_W'(D)) ? IDX_W'(D) : i_entry_index;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= start && !busy;
        end
        r_s1_num <= NUM_W'(w_idx) * NUM_W'(w_seg);
        r_s1_seg <= w_seg;
    end

    // stage 2: segment search by threshold compares, fraction numerator
    logic             r_s2_valid;
    logic [CNT_W-1:0] r_s2_from;
    logic [CNT_W-1:0] r_s2_seg;
    logic [IDX_W-1:0] r_s2_a;
    logic [CNT_W-1:0] n_from;
    logic [NUM_W-1:0] w_base;

    always_comb begin
        n_from = '0;
        for (int k = 1; k < MAX_POINTS; k++) begin
            if (r_s1_num >= NUM_W'(k * D)) begin
                n_from = n_from + CNT_W'(1);
            end
        end
        // last entry stays on the final segment
        if (r_s1_seg != '0 && n_from >= r_s1_seg) begin
            n_from = r_s1_seg - CNT_W'(1);
        end
        w_base = NUM_W'(n_from) * NUM_W'(D);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else begin
            r_s2_valid <= r_s1_valid;
        end
        r_s2_from <= n_from;
        r_s2_seg  <= r_s1_seg;
        r_s2_a    <= IDX_W'(r_s1_num - w_base);
    end

    // smoothstep table: h(a) = floor(65536 * a^2 * (3d - 2a) / d^3), built at elaboration
    logic [H_W-1:0] w_htab [TAB_N];
    for (genvar k = 0; k < TAB_N; k++) begin : g_htab
        if (k <= D) begin : g_entry
            localparam logic [63:0] A  = 64'(k);
            localparam logic [63:0] DD = 64'(D);
            localparam logic [63:0] HV =
                (64'd65536 * A * A * (64'd3 * DD - 64'd2 * A)) / (DD * DD * DD);
            assign w_htab[k] = H_W'(HV);
        end else begin : g_pad
            assign w_htab[k] = '0;
        end
    end

    // neighbor point select
    logic [PT_W-1:0] w_pa;
    logic [PT_W-1:0] w_pb;
    always_comb begin
        w_pa = '0;
        w_pb = '0;
        for (int k = 0; k < MAX_POINTS; k++) begin
            if (int'(r_s2_from) == k) begin
                w_pa = r_points[k];
            end
            if (int'(r_s2_from) + 1 == k) begin
                w_pb = r_points[k];
            end
        end
    end

    // stage 3: table read, points registered
    logic            r_s3_valid;
    logic [H_W-1:0]  r_s3_h;
    logic [PT_W-1:0] r_s3_pa;
    logic [PT_W-1:0] r_s3_pb;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_valid <= 1'b0;
        end else begin
            r_s3_valid <= r_s2_valid;
        end
        r_s3_h  <= w_htab[r_s2_a];
        r_s3_pa <= w_pa;
        r_s3_pb <= w_pb;
    end

    // stage 4: weight each channel of both points
    logic              r_s4_valid;
    logic [PROD_W-1:0] r_s4_lo [NUM_CH];
    logic [PROD_W-1:0] r_s4_hi [NUM_CH];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s4_valid <= 1'b0;
        end else begin
            r_s4_valid <= r_s3_valid;
        end
        for (int c = 0; c < NUM_CH; c++) begin
            r_s4_lo[c] <= PROD_W'(chan_of(r_s3_pa, c)) * PROD_W'(H_ONE - r_s3_h);
            r_s4_hi[c] <= PROD_W'(chan_of(r_s3_pb, c)) * PROD_W'(r_s3_h);
        end
    end

    // stage 5: blend, saturate, convert to bytes
    logic [PROD_W:0]     w_sum  [NUM_CH];
    logic [CH_W-1:0]     w_chan [NUM_CH];
    logic [BYTE_W-1:0]   w_byte [NUM_CH];

    always_comb begin
        for (int c = 0; c < NUM_CH; c++) begin
            w_sum[c] = (PROD_W+1)'(r_s4_lo[c]) + (PROD_W+1)'(r_s4_hi[c]);
            if (w_sum[c][PROD_W:CH_W] > (PROD_W+1-CH_W)'(16'hFFFF)) begin
                w_chan[c] = '1;
            end else begin
                w_chan[c] = w_sum[c][2*CH_W-1:CH_W];
            end
            w_byte[c] = to_byte(w_chan[c]);
        end
    end

    logic              r_out_valid;
    logic [BYTE_W-1:0] r_red;
    logic [BYTE_W-1:0] r_green;
    logic [BYTE_W-1:0] r_blue;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= r_s4_valid;
        end
        r_red <= w_byte[0];
        // single-channel mode clears green and blue
        if (r_channel_mode == MODE_SINGLE) begin
            r_green <= '0;
            r_blue  <= '0;
        end else begin
            r_green <= w_byte[1];
            r_blue  <= w_byte[2];
        end
    end

    assign o_strobe     = r_out_valid;
    assign o_red_byte   = r_red;
    assign o_green_byte = r_green;
    assign o_blue_byte  = r_blue;

    // every accepted word comes out as a result strobe at the end of the pipeline
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##5 o_strobe)
        else $error("result missing five cycles after request");

    // no result without a matching earlier request
    a_no_phantom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(start && !busy, 5))
        else $error("result without matching request");

    // segment search never runs past the last segment
    a_seg_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s2_valid && r_s2_seg != '0) |-> (r_s2_from < r_s2_seg))
        else $error("segment number out of range");

endmodule

// ===== bench/tb_smoothstep_gradient_ramp_top.sv =====
// Self-checking bench for smoothstep_gradient_ramp_top: bursty ramp requests
// against a scoreboard that predicts each RGB word. Depends on sgr_pkg and the top.
`timescale 1ns / 100ps

module tb_smoothstep_gradient_ramp_top;
    import sgr_pkg::*;

    localparam int RAMP_LEN = 128;
    localparam int MAX_PTS  = 6;
    localparam int IDX_W    = $clog2(RAMP_LEN);
    localparam int NUM_REGS = 8;
    localparam logic MODE_FULL = ~MODE_SINGLE;
    localparam logic [CH_W-1:0] CH_FULL = '1;

    typedef logic [PT_W-1:0] point_t;
    typedef struct packed {
        logic [BYTE_W-1:0] red;
        logic [BYTE_W-1:0] green;
        logic [BYTE_W-1:0] blue;
    } rgb_t;

    // Expected-color store with its own copy of the ramp registers
    class ramp_scoreboard;
        logic [CNT_W-1:0] point_count;
        logic             channel_mode;
        point_t           points [MAX_PTS];
        rgb_t             color_q [$];
        int               err_count;
        int               result_num;

        function new();
            point_count  = 3'd2;
            channel_mode = MODE_FULL;
            foreach (points[k]) points[k] = '0;
            points[1]  = '1;
            err_count  = 0;
            result_num = 0;
        endfunction

        function void note_config(logic [CFG_IDX_W-1:0] idx, point_t data);
            if (idx == REG_POINT_COUNT) begin
                point_count = data[CNT_W-1:0];
            end else if (idx == REG_CHANNEL_MODE) begin
                channel_mode = data[0];
            end else begin
                points[idx - REG_POINT_0] = data;
            end
        endfunction

        // smoothstep blend of the two neighboring points, then byte scaling
        function rgb_t ramp_color(logic [IDX_W-1:0] idx);
            longint unsigned n, s, num, seg, frac, d, shaped, ca, cb, v;
            point_t p_lo, p_hi;
            logic [BYTE_W-1:0] chan_byte [NUM_CH];
            rgb_t c;
            d = 64'(RAMP_LEN - 1);
            n = 64'(point_count);
            if (n == 0) n = 1;
            if (n > MAX_PTS) n = 64'(MAX_PTS);
            if (n == 1) begin
                p_lo   = points[0];
                p_hi   = points[0];
                shaped = 0;
            end else begin
                s   = n - 1;
                num = 64'(idx) * s;
                seg = num / d;
                if (seg >= s) seg = s - 1;   // last entry stays in final segment
                frac   = num - seg * d;
                shaped = (64'd65536 * frac * frac * (3 * d - 2 * frac)) / (d * d * d);
                if (shaped > 64'd65536) shaped = 64'd65536;
                p_lo = points[seg];
                p_hi = points[seg + 1];
            end
            for (int ch = 0; ch < NUM_CH; ch++) begin
                ca = 64'(p_lo[(NUM_CH - 1 - ch) * CH_W +: CH_W]);
                cb = 64'(p_hi[(NUM_CH - 1 - ch) * CH_W +: CH_W]);
                v  = (ca * (64'd65536 - shaped) + cb * shaped) >> 16;
                if (v > 64'hFFFF) v = 64'hFFFF;
                if (channel_mode == MODE_SINGLE && ch != 0) chan_byte[ch] = '0;
                else if (v == 0) chan_byte[ch] = '0;
                else chan_byte[ch] = BYTE_W'((v * 255 - 1) >> 16);
            end
            c.red   = chan_byte[0];
            c.green = chan_byte[1];
            c.blue  = chan_byte[2];
            return c;
        endfunction

        function void note_request(logic [IDX_W-1:0] idx);
            color_q.push_back(ramp_color(idx));
        endfunction

        function int pending();
            return color_q.size();
        endfunction

        task report_mismatch(string msg);
            if (err_count < 50) $display("[%0t] ERROR: %s", $realtime, msg);
            err_count++;
        endtask

        task check_result(rgb_t got);
            rgb_t want;
            if (color_q.size() == 0) begin
                report_mismatch($sformatf("unexpected word %h", got));
            end else begin
                want = color_q.pop_front();
                if (got.red != want.red)
                    report_mismatch($sformatf("word %0d red %0d, expected %0d",
                                              result_num, got.red, want.red));
                if (got.green != want.green)
                    report_mismatch($sformatf("word %0d green %0d, expected %0d",
                                              result_num, got.green, want.green));
                if (got.blue != want.blue)
                    report_mismatch($sformatf("word %0d blue %0d, expected %0d",
                                              result_num, got.blue, want.blue));
            end
            result_num++;
        endtask
    endclass

    logic                 i_clk         = 1'b0;
    logic                 i_rst_n       = 1'b0;
    logic                 start         = 1'b0;
    logic                 busy;
    logic [IDX_W-1:0]     i_entry_index = '0;
    logic                 o_strobe;
    logic [BYTE_W-1:0]    o_red_byte;
    logic [BYTE_W-1:0]    o_green_byte;
    logic [BYTE_W-1:0]    o_blue_byte;
    logic                 i_cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index   = '0;
    point_t               i_cfg_data    = '0;

    ramp_scoreboard sb = new();
    point_t         pts [MAX_PTS];

    smoothstep_gradient_ramp_top #(
        .RAMP_LENGTH (RAMP_LEN),
        .MAX_POINTS  (MAX_PTS)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_entry_index (i_entry_index),
        .o_strobe      (o_strobe),
        .o_red_byte    (o_red_byte),
        .o_green_byte  (o_green_byte),
        .o_blue_byte   (o_blue_byte),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always #2 i_clk = ~i_clk;

    // Monitor: everything sampled at the edge that accepts it
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_we) sb.note_config(i_cfg_index, i_cfg_data);
            if (start && !busy) sb.note_request(i_entry_index);
            if (o_strobe) sb.check_result({o_red_byte, o_green_byte, o_blue_byte});
        end
    end

    // one request word; returns at the edge that took it
    task automatic send_index(input logic [IDX_W-1:0] idx);
        start         <= 1'b1;
        i_entry_index <= idx;
        do @(posedge i_clk); while (busy);
    endtask

    task automatic idle(input int cycles);
        start <= 1'b0;
        repeat (cycles) @(posedge i_clk);
    endtask

    // hold requests until every expected word is back
    task automatic wait_drained();
        start <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    // writes every register once; only called with the pipeline empty
    task automatic load_config(input logic [CNT_W-1:0] count, input logic mode,
                               input point_t p [MAX_PTS]);
        point_t data;
        for (int r = 0; r < NUM_REGS; r++) begin
            if (r == REG_POINT_COUNT) data = PT_W'(count);
            else if (r == REG_CHANNEL_MODE) data = PT_W'(mode);
            else data = p[r - REG_POINT_0];
            i_cfg_we    <= 1'b1;
            i_cfg_index <= CFG_IDX_W'(r);
            i_cfg_data  <= data;
            @(posedge i_clk);
        end
        i_cfg_we <= 1'b0;
    endtask

    function automatic logic [CH_W-1:0] rand_channel();
        case ($urandom_range(0, 4))
            0: return '0;
            1: return CH_FULL;
            2: return CH_W'(1);
            default: return CH_W'($urandom_range(0, 65535));
        endcase
    endfunction

    function automatic point_t rand_point();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return '1;
            2: return {rand_channel(), rand_channel(), rand_channel()};
            default: return {CH_W'($urandom), CH_W'($urandom), CH_W'($urandom)};
        endcase
    endfunction

    // ramp ends are weighted up, the rest uniform
    function automatic logic [IDX_W-1:0] pick_index();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            default: return IDX_W'($urandom_range(0, RAMP_LEN - 1));
        endcase
    endfunction

    // bursts of random length with random gaps, some bursts back to back, optionally drained once midway
    task automatic run_traffic(input int n_items, input bit hold_midway);
        int sent, burst, gap;
        bit held;
        sent = 0;
        held = 1'b0;
        while (sent < n_items) begin
            burst = $urandom_range(1, 24);
            gap   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
            for (int k = 0; k < burst && sent < n_items; k++) begin
                send_index(pick_index());
                sent++;
            end
            if (hold_midway && !held && sent >= n_items / 2) begin
                wait_drained();
                held = 1'b1;
            end
            if (gap > 0) idle(gap);
        end
        wait_drained();
    endtask

    // Stimulus
    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset registers: two points, black to white
        send_index('0);
        send_index(IDX_W'(1));
        send_index(IDX_W'(63));
        send_index(IDX_W'(64));
        send_index(IDX_W'(126));
        send_index('1);
        wait_drained();

        // six points, full scale alternating, segment edges
        foreach (pts[k]) pts[k] = (k % 2 == 0) ? '1 : '0;
        pts[5] = {CH_FULL, 16'h0000, 16'h8000};
        load_config(3'd6, MODE_FULL, pts);
        send_index('0);
        send_index(IDX_W'(25));
        send_index(IDX_W'(26));
        send_index(IDX_W'(51));
        send_index('1);
        wait_drained();

        // single point, single channel
        pts[0] = {CH_FULL, 16'h0001, 16'h8000};
        load_config(3'd1, MODE_SINGLE, pts);
        send_index('0);
        send_index('1);
        wait_drained();

        // zero point count acts as one point
        pts[0] = {16'h0001, CH_FULL, 16'h1234};
        load_config(3'd0, MODE_FULL, pts);
        send_index(IDX_W'(5));
        send_index('1);
        wait_drained();

        // point count above the limit saturates
        foreach (pts[k]) pts[k] = rand_point();
        load_config(3'd7, MODE_FULL, pts);
        send_index('0);
        send_index(IDX_W'(126));
        send_index('1);
        wait_drained();

        load_config(3'd3, MODE_SINGLE, pts);
        send_index(IDX_W'(63));
        send_index(IDX_W'(64));
        wait_drained();

        // random phases, every point count once, then random counts
        for (int ph = 0; ph < 10; ph++) begin
            foreach (pts[k]) pts[k] = rand_point();
            load_config((ph < 8) ? CNT_W'(ph) : CNT_W'($urandom_range(0, 7)),
                        ($urandom_range(0, 3) == 0) ? MODE_SINGLE : MODE_FULL, pts);
            run_traffic(145, ph == 3);
        end

        // catch stray words after the last one
        repeat (10) @(posedge i_clk);
        if (sb.pending() != 0)
            sb.report_mismatch($sformatf("%0d words never came", sb.pending()));
        if (sb.err_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    // watchdog
    initial begin
        #2_000_000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule
